// File: hw/rtl/stq_pkg.sv
// Types and constants of the sorted timer queue.
// Used by stq_cell and sorted_timer_queue; depends on nothing.
`default_nettype none
package stq_pkg;

  localparam int TIMER_W = 4;
  localparam int TIME_W  = 32;
  localparam int IDLE_MINUTES   = 30;
  localparam int TICKS_PER_MIN  = 60000;
  localparam logic [TIME_W-1:0] IDLE_DELAY_RST = TIME_W'(IDLE_MINUTES * TICKS_PER_MIN);

  typedef enum logic [1:0] {
    KIND_ARM    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_PROC   = 2'd2,
    KIND_QUERY  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    RES_ACCEPTED = 3'd0,
    RES_FULL     = 3'd1,
    RES_NOTFOUND = 3'd2,
    RES_EXPIRED  = 3'd3,
    RES_NONE     = 3'd4,
    RES_DELAY    = 3'd5
  } res_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_REMOVE = 2'd1,
    OP_INSERT = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_FIND   = 3'd1,
    ST_INSERT = 3'd2,
    ST_QUERY  = 3'd3,
    ST_PROC   = 3'd4,
    ST_REARM  = 3'd5
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [TIMER_W-1:0] timer;
    logic [TIME_W-1:0]  expiry;
    logic [TIME_W-1:0]  period;
    logic               rep;
  } entry_t;

  typedef struct packed {
    op_t                op;
    logic               rm_head;
    logic [TIMER_W-1:0] key_id;
    entry_t             new_e;
  } chain_ctl_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/stq_cell.sv
// One slot of the sorted chain: holds an entry, shifts left on remove,
// right on insert. Depends on stq_pkg.
`default_nettype none
module stq_cell
  import stq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire chain_ctl_t ctl,
  input  wire entry_t     prev_e,
  input  wire entry_t     next_e,
  input  wire logic       rm_in,
  input  wire logic       ins_in,
  output logic            rm_out,
  output logic            ins_out,
  output entry_t          cur_e
);

  entry_t e_r;
  entry_t e_nxt;
  logic   hit;
  logic   ins_here;

  assign hit      = e_r.valid && (e_r.timer == ctl.key_id);
  assign ins_here = !e_r.valid || (e_r.expiry > ctl.new_e.expiry);
  assign rm_out   = rm_in || hit;
  assign ins_out  = ins_here;
  assign cur_e    = e_r;

  always_comb begin
    e_nxt = e_r;
    unique case (ctl.op)
      OP_REMOVE: begin
        if (rm_out) e_nxt = next_e;
      end
      OP_INSERT: begin
        if (ins_in) e_nxt = prev_e;
        else if (ins_here) e_nxt = ctl.new_e;
      end
      default: e_nxt = e_r;
    endcase
  end

  // only the valid bit is reset; the payload follows it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r.valid <= 1'b0;
    end else begin
      e_r.valid <= e_nxt.valid;
    end
    e_r.timer  <= e_nxt.timer;
    e_r.expiry <= e_nxt.expiry;
    e_r.period <= e_nxt.period;
    e_r.rep    <= e_nxt.rep;
  end

endmodule
`default_nettype wire

// File: hw/rtl/sorted_timer_queue.sv
// Top level of the sorted timer queue: command sequencer, chain of slot cells,
// result register. Depends on stq_pkg and stq_cell.
//
// Holds up to DEPTH timers in a chain of cells sorted by absolute expiry,
// ties in arming order. One transaction is worked at a time. Arm goes through
// find, then sorted insert; cancel goes through find alone, query through the
// query step alone. Process works each expired timer in turn (remove the head,
// then re-insert a repeating timer at now plus period) and emits one result
// transaction per expired timer, or one "none expired" result.
// A result waits in a single output register; every step that needs that
// register holds while a stalled result stays in it.
// Every insert or remove is one shift of the chain behind the changed slot.
`default_nettype none
module sorted_timer_queue
  import stq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_wr_en,
  input  wire logic [TIME_W-1:0]  cfg_wr_data,
  // command channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_kind,
  input  wire logic [TIMER_W-1:0] in_timer_id,
  input  wire logic [TIME_W-1:0]  in_now,
  input  wire logic [TIME_W-1:0]  in_delay,
  input  wire logic [TIME_W-1:0]  in_period,
  input  wire logic               in_repeat_req,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              out_result_kind,
  output logic [TIMER_W-1:0]      out_expired_id,
  output logic [TIME_W-1:0]       out_remaining,
  output logic                    out_last
);

  // configuration register
  logic [TIME_W-1:0] idle_delay_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_delay_r <= IDLE_DELAY_RST;
    end else if (cfg_wr_en) begin
      idle_delay_r <= cfg_wr_data;
    end
  end

  // cell chain
  chain_ctl_t   ctl;
  entry_t       cell_e [DEPTH];
  logic [DEPTH:0] rm_c;
  logic [DEPTH:0] ins_c;

  assign rm_c[0]  = ctl.rm_head;
  assign ins_c[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t prev_w;
    entry_t next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid
      assign prev_w = cell_e[i-1];
    end
    if (i == DEPTH-1) begin : g_last
      assign next_w = '0;
    end else begin : g_nlast
      assign next_w = cell_e[i+1];
    end
    stq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .prev_e  (prev_w),
      .next_e  (next_w),
      .rm_in   (rm_c[i]),
      .ins_in  (ins_c[i]),
      .rm_out  (rm_c[i+1]),
      .ins_out (ins_c[i+1]),
      .cur_e   (cell_e[i])
    );
  end

  // latched command
  kind_t              kind_r;
  logic [TIMER_W-1:0] id_r;
  logic [TIME_W-1:0]  now_r;
  logic [TIME_W-1:0]  period_r;
  logic               rep_r;
  logic [TIME_W-1:0]  exp_r;
  logic               first_r;
  logic               done_r;

  // re-arm candidate captured at head removal
  logic [TIMER_W-1:0] ra_id_r;
  logic [TIME_W-1:0]  ra_period_r;
  logic               ra_rep_r;

  state_t state_r, state_nxt;

  // result register
  logic               out_valid_r;
  res_t               res_kind_r;
  logic [TIMER_W-1:0] res_id_r;
  logic [TIME_W-1:0]  res_rem_r;
  logic               res_last_r;

  logic               out_free;
  logic               in_take;
  logic               emit;
  res_t               emit_kind;
  logic [TIMER_W-1:0] emit_id;
  logic [TIME_W-1:0]  emit_rem;
  logic               emit_last;
  logic               head_due;
  logic               next_due;
  logic               any_hit;
  logic               full;
  logic               take_head;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign head_due = cell_e[0].valid && (cell_e[0].expiry < now_r);
  assign next_due = cell_e[1].valid && (cell_e[1].expiry < now_r);
  assign any_hit  = rm_c[DEPTH];
  assign full     = cell_e[DEPTH-1].valid;

  always_comb begin
    state_nxt  = state_r;
    ctl        = '0;
    ctl.op     = OP_HOLD;
    ctl.key_id = id_r;
    emit       = 1'b0;
    emit_kind  = RES_ACCEPTED;
    emit_id    = id_r;
    emit_rem   = '0;
    emit_last  = 1'b1;
    take_head  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          unique case (kind_t'(in_kind))
            KIND_ARM, KIND_CANCEL: state_nxt = ST_FIND;
            KIND_PROC:             state_nxt = ST_PROC;
            default:               state_nxt = ST_QUERY;
          endcase
        end
      end
      ST_FIND: begin
        if (out_free) begin
          if (any_hit) begin
            ctl.op = OP_REMOVE;
          end
          if (kind_r == KIND_ARM) begin
            // drop any pending copy, then insert in ST_INSERT
            if (!any_hit && full) begin
              emit      = 1'b1;
              emit_kind = RES_FULL;
              state_nxt = ST_IDLE;
            end else begin
              state_nxt = ST_INSERT;
            end
          end else begin
            emit      = 1'b1;
            emit_kind = any_hit ? RES_ACCEPTED : RES_NOTFOUND;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_INSERT: begin
        if (out_free) begin
          ctl.op           = OP_INSERT;
          ctl.new_e.valid  = 1'b1;
          ctl.new_e.timer  = id_r;
          ctl.new_e.expiry = exp_r;
          ctl.new_e.period = period_r;
          ctl.new_e.rep    = rep_r;
          emit             = 1'b1;
          emit_kind        = RES_ACCEPTED;
          state_nxt        = ST_IDLE;
        end
      end
      ST_QUERY: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_kind = RES_DELAY;
          if (cell_e[0].valid) begin
            emit_id  = cell_e[0].timer;
            emit_rem = (cell_e[0].expiry > now_r) ? (cell_e[0].expiry - now_r) : '0;
          end else begin
            emit_id  = '0;
            emit_rem = idle_delay_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_PROC: begin
        if (out_free) begin
          if (head_due) begin
            // pop the head; a repeating timer is re-inserted next cycle
            ctl.op      = OP_REMOVE;
            ctl.rm_head = 1'b1;
            ctl.key_id  = cell_e[0].timer;
            take_head   = 1'b1;
            emit        = 1'b1;
            emit_kind   = RES_EXPIRED;
            emit_id     = cell_e[0].timer;
            emit_last   = !next_due;
            state_nxt   = ST_REARM;
          end else begin
            emit      = first_r;
            emit_kind = RES_NONE;
            emit_id   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_REARM: begin
        if (ra_rep_r) begin
          ctl.op           = OP_INSERT;
          ctl.new_e.valid  = 1'b1;
          ctl.new_e.timer  = ra_id_r;
          ctl.new_e.expiry = exp_r;
          ctl.new_e.period = ra_period_r;
          ctl.new_e.rep    = 1'b1;
        end
        state_nxt = done_r ? ST_IDLE : ST_PROC;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // hold the command and the re-arm candidate
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_r   <= kind_t'(in_kind);
      id_r     <= in_timer_id;
      now_r    <= in_now;
      period_r <= in_period;
      rep_r    <= in_repeat_req;
      exp_r    <= sat_add(in_now, in_delay);
      first_r  <= 1'b1;
    end else if (take_head) begin
      ra_id_r     <= cell_e[0].timer;
      ra_period_r <= cell_e[0].period;
      ra_rep_r    <= cell_e[0].rep;
      exp_r       <= sat_add(now_r, cell_e[0].period);
      done_r      <= !next_due;
      first_r     <= 1'b0;
    end
  end

  // result register: load on emit, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_kind_r <= emit_kind;
      res_id_r   <= emit_id;
      res_rem_r  <= emit_rem;
      res_last_r <= emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = res_kind_r;
  assign out_expired_id  = res_id_r;
  assign out_remaining   = res_rem_r;
  assign out_last        = res_last_r;

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for sorted_timer_queue: directed and random commands,
// predicted against a behavioral queue model. Depends on stq_pkg and the RTL.
`timescale 1ns / 100ps
module tb;
  import stq_pkg::*;

  localparam int NSLOT = 16;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [TIME_W-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = '0;
  logic [TIMER_W-1:0] in_timer_id = '0;
  logic [TIME_W-1:0] in_now = '0, in_delay = '0, in_period = '0;
  logic in_repeat_req = 1'b0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [2:0] out_result_kind;
  logic [TIMER_W-1:0] out_expired_id;
  logic [TIME_W-1:0] out_remaining;
  logic out_last;

  sorted_timer_queue dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_timer_id(in_timer_id), .in_now(in_now), .in_delay(in_delay),
    .in_period(in_period), .in_repeat_req(in_repeat_req),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_kind(out_result_kind), .out_expired_id(out_expired_id),
    .out_remaining(out_remaining), .out_last(out_last)
  );

  always #4 clk = ~clk;

  typedef struct {
    res_t               kind;
    logic [TIMER_W-1:0] id;
    logic [TIME_W-1:0]  remaining;
    logic               last;
  } result_t;

  // Model of the timer list: entries [0..q_count-1] are pending, sorted by expiry.
  logic [TIMER_W-1:0] q_id  [NSLOT];
  logic [TIME_W-1:0]  q_exp [NSLOT];
  logic [TIME_W-1:0]  q_per [NSLOT];
  logic               q_rep [NSLOT];
  int                 q_count = 0;
  logic [TIME_W-1:0]  idle_ticks = IDLE_DELAY_RST;

  result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit hold_off = 1'b0;     // long receiver stall, set by a test
  bit quiet_out = 1'b0;    // no random receiver stalls

  function automatic logic [TIME_W-1:0] add_sat(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? '1 : s[TIME_W-1:0];
  endfunction

  function automatic int find_pos(logic [TIMER_W-1:0] id);
    for (int i = 0; i < q_count; i++)
      if (q_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_at(int p);
    for (int j = p; j + 1 < q_count; j++) begin
      q_id[j] = q_id[j+1]; q_exp[j] = q_exp[j+1];
      q_per[j] = q_per[j+1]; q_rep[j] = q_rep[j+1];
    end
    q_count--;
  endfunction

  // Insert after every entry with expiry <= new one, so ties keep arming order.
  function automatic void place_sorted(logic [TIMER_W-1:0] id, logic [TIME_W-1:0] ex,
                                       logic [TIME_W-1:0] per, logic rep);
    int p;
    p = q_count;
    while (p > 0 && q_exp[p-1] > ex) p--;
    for (int j = q_count; j > p; j--) begin
      q_id[j] = q_id[j-1]; q_exp[j] = q_exp[j-1];
      q_per[j] = q_per[j-1]; q_rep[j] = q_rep[j-1];
    end
    q_id[p] = id; q_exp[p] = ex; q_per[p] = per; q_rep[p] = rep;
    q_count++;
  endfunction

  function automatic void expect_result(res_t k, logic [TIMER_W-1:0] id,
                                        logic [TIME_W-1:0] rem, logic last);
    result_t r;
    r.kind = k; r.id = id; r.remaining = rem; r.last = last;
    pending_results.push_back(r);
  endfunction

  // Work out the results of one accepted command and advance the model.
  function automatic void predict_command(kind_t k, logic [TIMER_W-1:0] id,
                                          logic [TIME_W-1:0] now, logic [TIME_W-1:0] dly,
                                          logic [TIME_W-1:0] per, logic rep);
    int p, n;
    logic [TIMER_W-1:0] ids [NSLOT];
    logic [TIME_W-1:0]  pers[NSLOT];
    logic               reps[NSLOT];
    p = find_pos(id);
    n = 0;
    case (k)
      KIND_ARM: begin
        if (p >= 0) drop_at(p);
        if (p < 0 && q_count >= NSLOT) expect_result(RES_FULL, id, '0, 1'b1);
        else begin
          place_sorted(id, add_sat(now, dly), per, rep);
          expect_result(RES_ACCEPTED, id, '0, 1'b1);
        end
      end
      KIND_CANCEL: begin
        if (p < 0) expect_result(RES_NOTFOUND, id, '0, 1'b1);
        else begin
          drop_at(p);
          expect_result(RES_ACCEPTED, id, '0, 1'b1);
        end
      end
      KIND_PROC: begin
        // Strictly earlier than now only.
        while (n < q_count && q_exp[n] < now) begin
          ids[n] = q_id[n]; pers[n] = q_per[n]; reps[n] = q_rep[n];
          n++;
        end
        if (n == 0) expect_result(RES_NONE, '0, '0, 1'b1);
        for (int i = 0; i < n; i++) drop_at(0);
        for (int i = 0; i < n; i++) begin
          expect_result(RES_EXPIRED, ids[i], '0, i == n - 1);
          if (reps[i]) place_sorted(ids[i], add_sat(now, pers[i]), pers[i], 1'b1);
        end
      end
      default: begin
        if (q_count == 0) expect_result(RES_DELAY, '0, idle_ticks, 1'b1);
        else expect_result(RES_DELAY, q_id[0], q_exp[0] > now ? q_exp[0] - now : '0, 1'b1);
      end
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  bit gaps_on = 1'b1;

  // Send one command; gaps before it, held until the block takes it.
  // Always wait for a further falling edge first so the drop of valid from the previous
  // command never lands on the same edge as the next drive.
  task automatic send_command(kind_t k, logic [TIMER_W-1:0] id, logic [TIME_W-1:0] now,
                              logic [TIME_W-1:0] dly, logic [TIME_W-1:0] per, logic rep);
    int g;
    g = gaps_on ? gap_len() : 0;
    repeat (g + 1) @(negedge clk);
    in_valid <= 1'b1; in_kind <= k; in_timer_id <= id; in_now <= now;
    in_delay <= dly; in_period <= per; in_repeat_req <= rep;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_command(k, id, now, dly, per, rep);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Receiver stall pattern, changed at the falling edge.
  int stall_left = 0;
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet_out && $urandom_range(0, 3) == 0) begin
      stall_left = gap_len();
      out_stall <= 1'b1;
    end else out_stall <= 1'b0;
  end

  // Check each result transaction against the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("unexpected result kind %0d id %0d at cycle %0d",
                 out_result_kind, out_expired_id, cycles);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_result_kind != want.kind) report_mismatch("kind", out_result_kind, want.kind);
        if (out_expired_id != want.id) report_mismatch("id", out_expired_id, want.id);
        if (out_remaining != want.remaining)
          report_mismatch("remaining", out_remaining, want.remaining);
        if (out_last != want.last) report_mismatch("last", out_last, want.last);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic drain_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_idle_delay(logic [TIME_W-1:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1; cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    idle_ticks = v;
  endtask

  function automatic logic [TIME_W-1:0] rand_time();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 20);
      1: return '1 - $urandom_range(0, 20);
      default: return $urandom();
    endcase
  endfunction

  // Extremes, every command kind and the named corner cases.
  task automatic test_directed();
    send_command(KIND_QUERY, 4'd0, 32'd5, '0, '0, 1'b0);          // empty: idle delay
    send_command(KIND_PROC, 4'd0, '1, '0, '0, 1'b0);               // none expired
    send_command(KIND_CANCEL, 4'd7, '0, '0, '0, 1'b0);             // not found
    send_command(KIND_ARM, 4'd15, '1, '1, '1, 1'b1);               // saturating expiry
    send_command(KIND_ARM, 4'd3, 32'd100, 32'd50, 32'd10, 1'b1);
    send_command(KIND_ARM, 4'd4, 32'd100, 32'd50, 32'd0, 1'b0);    // tie: after timer 3
    send_command(KIND_QUERY, 4'd0, 32'd120, '0, '0, 1'b0);
    send_command(KIND_QUERY, 4'd0, 32'd200, '0, '0, 1'b0);         // already due
    send_command(KIND_PROC, 4'd0, 32'd150, '0, '0, 1'b0);          // equal: not expired
    send_command(KIND_PROC, 4'd0, 32'd151, '0, '0, 1'b0);          // 3 rearms, 4 dropped
    send_command(KIND_ARM, 4'd3, 32'd10, 32'd5, 32'd0, 1'b0);      // reschedule
    send_command(KIND_CANCEL, 4'd3, '0, '0, '0, 1'b0);
    send_command(KIND_ARM, 4'd9, 32'hFFFF_FFF0, 32'h20, 32'hFFFF_FFFF, 1'b1);
    send_command(KIND_PROC, 4'd0, '1, '0, '0, 1'b0);
    for (int i = 0; i < 16; i++)                                   // fill up
      send_command(KIND_ARM, 4'(i), 32'd1000, 32'(i % 3), 32'd7, 1'(i & 1));
    drain_results();
  endtask

  task automatic test_full_queue();
    send_command(KIND_ARM, 4'd5, 32'd0, 32'd1, 32'd1, 1'b0);       // pending: accepted
    send_command(KIND_PROC, 4'd0, '1, '0, '0, 1'b0);               // up to 16 results
    send_command(KIND_QUERY, 4'd0, '0, '0, '0, 1'b0);
    drain_results();
  endtask

  // Receiver holds off while commands keep coming so the block backs up.
  task automatic test_backpressure();
    int held;
    hold_off = 1'b1;
    gaps_on = 1'b0;
    fork
      begin
        held = 0;
        while (held < 200) begin
          @(posedge clk);
          held++;
        end
        hold_off = 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_command(kind_t'($urandom_range(0, 3)), 4'($urandom()), $urandom_range(0, 500),
                     $urandom_range(0, 300), $urandom_range(0, 50), 1'($urandom()));
    join
    gaps_on = 1'b1;
    drain_results();
  endtask

  task automatic test_random(int n);
    logic [TIME_W-1:0] clock_now;
    int pick;
    clock_now = $urandom_range(0, 1000);
    for (int i = 0; i < n; i++) begin
      quiet_out = (i / 40) % 3 == 2;
      gaps_on = (i / 40) % 3 != 1;
      pick = $urandom_range(0, 99);
      // Mostly a slowly advancing clock so timers really expire and rearm.
      if ($urandom_range(0, 15) == 0) clock_now = rand_time();
      else clock_now = add_sat(clock_now, $urandom_range(0, 40));
      if (pick < 45)
        send_command(KIND_ARM, 4'($urandom()), clock_now,
                     ($urandom_range(0, 9) == 0) ? rand_time() : $urandom_range(0, 120),
                     ($urandom_range(0, 9) == 0) ? rand_time() : $urandom_range(0, 80),
                     1'($urandom()));
      else if (pick < 60)
        send_command(KIND_CANCEL, 4'($urandom()), rand_time(), rand_time(), rand_time(),
                     1'($urandom()));
      else if (pick < 85)
        send_command(KIND_PROC, 4'($urandom()), clock_now, rand_time(), rand_time(),
                     1'($urandom()));
      else
        send_command(KIND_QUERY, 4'($urandom()),
                     ($urandom_range(0, 4) == 0) ? rand_time() : clock_now,
                     rand_time(), rand_time(), 1'($urandom()));
    end
    quiet_out = 1'b0;
    gaps_on = 1'b1;
    drain_results();
  endtask

  task automatic test_config();
    write_idle_delay('0);
    send_command(KIND_PROC, 4'd0, '1, '0, '0, 1'b0);   // empty the queue where possible
    send_command(KIND_PROC, 4'd0, '1, '0, '0, 1'b0);
    for (int i = 0; i < 16; i++) send_command(KIND_CANCEL, 4'(i), '0, '0, '0, 1'b0);
    send_command(KIND_QUERY, 4'd0, '1, '0, '0, 1'b0);
    drain_results();
    write_idle_delay('1);
    send_command(KIND_QUERY, 4'd0, '0, '0, '0, 1'b0);
    drain_results();
    write_idle_delay($urandom());
    send_command(KIND_QUERY, 4'd0, $urandom(), '0, '0, 1'b0);
    drain_results();
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_full_queue();
    test_config();
    test_backpressure();
    test_random(120);
    test_config();
    test_random(110);
    drain_results();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: sorted_timer_queue.f
hw/rtl/stq_pkg.sv
hw/rtl/stq_cell.sv
hw/rtl/sorted_timer_queue.sv
tb/sv/tb.sv
